// ===== rtl/hapid_pkg.sv =====
// Shared types, constants and helper functions for the heading PID core.
`timescale 1ns / 1ps

package hapid_pkg;

  // Configuration register indexes (word address = index * 4)
  typedef enum logic [2:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_INTEG_LIM  = 3'd3,
    CFG_STEP_LIM   = 3'd4,
    CFG_OUT_LIM    = 3'd5
  } cfg_idx_t;

  localparam int unsigned APB_ADDR_W = 5;

  // Register reset values
  localparam logic [23:0] PROP_GAIN_RST  = 24'd131072;
  localparam logic [23:0] INTEG_GAIN_RST = 24'd1311;
  localparam logic [23:0] DERIV_GAIN_RST = 24'd98304;
  localparam logic [26:0] INTEG_LIM_RST  = 27'd65536;
  localparam logic [23:0] STEP_LIM_RST   = 24'd0;
  localparam logic [23:0] OUT_LIM_RST    = 24'd39322;

  // Angle and loop constants (Q16.16 / Q9.16)
  localparam logic signed [25:0] HALF_TURN    = 26'sd11796480;
  localparam logic signed [25:0] FULL_TURN    = 26'sd23592960;
  localparam logic [23:0]        DEADBAND     = 24'd13107;
  localparam logic [23:0]        DEFAULT_STEP = 24'd13107;
  localparam logic [24:0]        DECAY_COEF   = 25'd64225;
  // ceil(2^32 / 250): x * RECIP_250 >> 32 == floor(x / 250) for x < 2^24
  localparam logic [24:0]        RECIP_250    = 25'd17179870;
  localparam logic [23:0]        HALF_RATE    = 24'd125;

  localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
  localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [23:0] deriv_gain;
    logic [26:0] integral_limit;
    logic [23:0] step_limit;
    logic [23:0] output_limit;
  } cfg_regs_t;

  // Operand selection for the shared multiplier
  typedef enum logic [1:0] {
    MS_UPDATE = 2'd0,  // integral decay or error / 250
    MS_PROP   = 2'd1,
    MS_DERIV  = 2'd2,
    MS_INTEG  = 2'd3
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_UPD,
    ST_INTEG,
    ST_MUL_DERIV,
    ST_MUL_INTEG,
    ST_ACC_LAST,
    ST_RATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     capture;     // latch the request fields
    logic     calc_err;    // wrapped heading error and derivative inputs
    logic     calc_deriv;  // derivative term
    logic     mul_en;      // load the product register
    mul_sel_t mul_sel;
    logic     upd_integ;   // write the integral sum
    logic     acc_first;   // first gain term into the drive sum
    logic     acc_add;     // add next gain term
    logic     calc_delta;  // rate-limited change
    logic     finish;      // load result, update history
  } ctrl_cmd_t;

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [41:0] r;
    r = v;
    if (v > SAT_MAX) r = SAT_MAX;
    else if (v < SAT_MIN) r = SAT_MIN;
    return r[31:0];
  endfunction

  // Symmetric clamp against a non-negative limit
  function automatic logic signed [41:0] clamp_sym(input logic signed [41:0] v,
                                                   input logic [26:0] lim);
    logic signed [41:0] l;
    l = $signed({15'b0, lim});
    if (v > l) return l;
    else if (v < -l) return -l;
    else return v;
  endfunction

endpackage

// ===== rtl/hapid_cfg.sv =====
// APB configuration register file for the heading PID core.
`timescale 1ns / 1ps

module hapid_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hapid_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output hapid_pkg::cfg_regs_t                cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[hapid_pkg::APB_ADDR_W-1:2];

  // Register writes; unused indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= hapid_pkg::PROP_GAIN_RST;
      cfg.integ_gain     <= hapid_pkg::INTEG_GAIN_RST;
      cfg.deriv_gain     <= hapid_pkg::DERIV_GAIN_RST;
      cfg.integral_limit <= hapid_pkg::INTEG_LIM_RST;
      cfg.step_limit     <= hapid_pkg::STEP_LIM_RST;
      cfg.output_limit   <= hapid_pkg::OUT_LIM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        hapid_pkg::CFG_PROP_GAIN:  cfg.prop_gain      <= pwdata[23:0];
        hapid_pkg::CFG_INTEG_GAIN: cfg.integ_gain     <= pwdata[23:0];
        hapid_pkg::CFG_DERIV_GAIN: cfg.deriv_gain     <= pwdata[23:0];
        hapid_pkg::CFG_INTEG_LIM:  cfg.integral_limit <= pwdata[26:0];
        hapid_pkg::CFG_STEP_LIM:   cfg.step_limit     <= pwdata[23:0];
        hapid_pkg::CFG_OUT_LIM:    cfg.output_limit   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      hapid_pkg::CFG_PROP_GAIN:  prdata = {8'b0, cfg.prop_gain};
      hapid_pkg::CFG_INTEG_GAIN: prdata = {8'b0, cfg.integ_gain};
      hapid_pkg::CFG_DERIV_GAIN: prdata = {8'b0, cfg.deriv_gain};
      hapid_pkg::CFG_INTEG_LIM:  prdata = {5'b0, cfg.integral_limit};
      hapid_pkg::CFG_STEP_LIM:   prdata = {8'b0, cfg.step_limit};
      hapid_pkg::CFG_OUT_LIM:    prdata = {8'b0, cfg.output_limit};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/hapid_ctrl.sv =====
// Sequencing state machine for the heading PID core.
`timescale 1ns / 1ps

module hapid_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  output logic                  drive_valid,
  input  logic                  drive_ready,
  output hapid_pkg::ctrl_cmd_t  cmd
);

  hapid_pkg::state_t state, state_next;
  logic              out_free;

  // Result slot can take a new value this cycle
  assign out_free = !drive_valid || drive_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= hapid_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Next state; the integral term is summed before the derivative term
  always_comb begin
    state_next = state;
    unique case (state)
      hapid_pkg::ST_IDLE:      if (sample_valid) state_next = hapid_pkg::ST_ERR;
      hapid_pkg::ST_ERR:       state_next = hapid_pkg::ST_MUL_UPD;
      hapid_pkg::ST_MUL_UPD:   state_next = hapid_pkg::ST_INTEG;
      hapid_pkg::ST_INTEG:     state_next = hapid_pkg::ST_MUL_INTEG;
      hapid_pkg::ST_MUL_INTEG: state_next = hapid_pkg::ST_MUL_DERIV;
      hapid_pkg::ST_MUL_DERIV: state_next = hapid_pkg::ST_ACC_LAST;
      hapid_pkg::ST_ACC_LAST:  state_next = hapid_pkg::ST_RATE;
      hapid_pkg::ST_RATE:      state_next = hapid_pkg::ST_DONE;
      hapid_pkg::ST_DONE:      if (out_free) state_next = hapid_pkg::ST_IDLE;
      default:                 state_next = hapid_pkg::ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = hapid_pkg::MS_UPDATE;
    sample_ready = 1'b0;
    unique case (state)
      hapid_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        cmd.capture  = sample_valid;
      end
      hapid_pkg::ST_ERR: cmd.calc_err = 1'b1;
      hapid_pkg::ST_MUL_UPD: begin
        cmd.calc_deriv = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = hapid_pkg::MS_UPDATE;
      end
      hapid_pkg::ST_INTEG: begin
        cmd.upd_integ = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = hapid_pkg::MS_PROP;
      end
      hapid_pkg::ST_MUL_INTEG: begin
        cmd.acc_first = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = hapid_pkg::MS_INTEG;
      end
      hapid_pkg::ST_MUL_DERIV: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = hapid_pkg::MS_DERIV;
      end
      hapid_pkg::ST_ACC_LAST: cmd.acc_add    = 1'b1;
      hapid_pkg::ST_RATE:     cmd.calc_delta = 1'b1;
      hapid_pkg::ST_DONE:     cmd.finish     = out_free;
      default: ;
    endcase
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst)              drive_valid <= 1'b0;
    else if (cmd.finish)  drive_valid <= 1'b1;
    else if (drive_ready) drive_valid <= 1'b0;
  end

endmodule

// ===== rtl/hapid_dp.sv =====
// Datapath of the heading PID core: error wrap, integral, shared multiplier, limits.
`timescale 1ns / 1ps

module hapid_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  hapid_pkg::ctrl_cmd_t        cmd,
  input  hapid_pkg::cfg_regs_t        cfg,
  input  logic signed [24:0]          measured_heading,
  input  logic signed [24:0]          target_heading,
  output logic signed [24:0]          drive_value
);

  logic signed [24:0] meas_r, targ_r, err_r;
  logic signed [31:0] deriv_r, raw_r;
  logic signed [57:0] prod;
  logic signed [27:0] integ;
  logic signed [25:0] delta_r;
  logic signed [24:0] prev_err, prev_drive;

  logic signed [25:0] err_diff, err_wrap;
  logic signed [24:0] err_mag;
  logic [23:0]        err_abs, recip_x, step_lim;
  logic               err_neg, dead;
  logic signed [25:0] de_diff;
  logic signed [34:0] de_ext, de_250;
  logic [24:0]        a_op;
  logic signed [31:0] b_op;
  logic signed [57:0] rnd_bias;
  logic signed [41:0] rnd;
  logic signed [31:0] term;
  logic [15:0]        quot;
  logic signed [16:0] quot_s;
  logic signed [28:0] integ_upd;
  logic signed [41:0] integ_clamped, delta_clamped, drive_clamped;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas_r <= measured_heading;
      targ_r <= target_heading;
    end
  end

  // Heading error, wrapped once into [-180, 180]
  assign err_diff = $signed({targ_r[24], targ_r}) - $signed({meas_r[24], meas_r});
  always_comb begin
    if (err_diff > hapid_pkg::HALF_TURN)       err_wrap = err_diff - hapid_pkg::FULL_TURN;
    else if (err_diff < -hapid_pkg::HALF_TURN) err_wrap = err_diff + hapid_pkg::FULL_TURN;
    else                                       err_wrap = err_diff;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_err) err_r <= err_wrap[24:0];
  end

  // Error magnitude, deadband test, rounding bias for / 250
  assign err_neg = err_r[24];
  assign err_mag = err_neg ? -err_r : err_r;
  assign err_abs = err_mag[23:0];
  assign dead    = err_abs <= hapid_pkg::DEADBAND;
  assign recip_x = err_abs + hapid_pkg::HALF_RATE;

  // Derivative: (err - prev_err) * 250 as shift-adds, saturated
  assign de_diff = $signed({err_r[24], err_r}) - $signed({prev_err[24], prev_err});
  assign de_ext  = 35'(de_diff);
  assign de_250  = (de_ext <<< 8) - (de_ext <<< 2) - (de_ext <<< 1);

  always_ff @(posedge clk) begin
    if (cmd.calc_deriv) deriv_r <= hapid_pkg::sat32(42'(de_250));
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      hapid_pkg::MS_UPDATE: begin
        if (dead) begin
          a_op = hapid_pkg::DECAY_COEF;
          b_op = 32'(integ);
        end else begin
          a_op = hapid_pkg::RECIP_250;
          b_op = $signed({8'b0, recip_x});
        end
      end
      hapid_pkg::MS_PROP: begin
        a_op = {1'b0, cfg.prop_gain};
        b_op = 32'(err_r);
      end
      hapid_pkg::MS_DERIV: begin
        a_op = {1'b0, cfg.deriv_gain};
        b_op = deriv_r;
      end
      hapid_pkg::MS_INTEG: begin
        a_op = {1'b0, cfg.integ_gain};
        b_op = 32'(integ);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= $signed({1'b0, a_op}) * b_op;
  end

  // Q16 rounding, ties away from zero
  assign rnd_bias = prod + (prod[57] ? 58'sd32767 : 58'sd32768);
  assign rnd      = rnd_bias[57:16];
  assign term     = hapid_pkg::sat32(rnd);

  // Quotient of |err| / 250 from the reciprocal product
  assign quot   = prod[47:32];
  assign quot_s = err_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  // Integral update: decay inside deadband, else accumulate, then clamp
  assign integ_upd = dead ? 29'($signed(rnd[27:0])) : 29'(integ) + 29'(quot_s);
  assign integ_clamped = hapid_pkg::clamp_sym(42'(integ_upd), cfg.integral_limit);

  always_ff @(posedge clk) begin
    if (rst)                integ <= '0;
    else if (cmd.upd_integ) integ <= integ_clamped[27:0];
  end

  // Drive sum of the three gain terms
  always_ff @(posedge clk) begin
    if (cmd.acc_first)    raw_r <= term;
    else if (cmd.acc_add) raw_r <= hapid_pkg::sat32(42'(raw_r) + 42'(term));
  end

  // Rate limit
  assign step_lim = (cfg.step_limit == '0) ? hapid_pkg::DEFAULT_STEP : cfg.step_limit;
  assign delta_clamped = hapid_pkg::clamp_sym(42'(raw_r) - 42'(prev_drive),
                                              {3'b0, step_lim});
  always_ff @(posedge clk) begin
    if (cmd.calc_delta) delta_r <= delta_clamped[25:0];
  end

  // Output clamp and history
  assign drive_clamped = hapid_pkg::clamp_sym(42'(prev_drive) + 42'(delta_r),
                                              {3'b0, cfg.output_limit});
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err   <= '0;
      prev_drive <= '0;
    end else if (cmd.finish) begin
      prev_err   <= err_r;
      prev_drive <= drive_clamped[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) drive_value <= drive_clamped[24:0];
  end

endmodule

// ===== rtl/heading_angle_pid_rate_limited_core.sv =====
// Top level of the heading PID core with angle wrap and rate-limited output.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  sample   | sample_valid/sample_ready  | measured_heading, target_heading
//  drive    | drive_valid/drive_ready    | drive_value
//  config   | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// One request at a time: a request is taken only in the idle state, and the
// sequencer returns there once the finish step finds the drive channel free.
// The sequence length is set by the single shared multiplier, which forms four
// products in sequence (integral update, P, I, D terms).
// Synchronous active-high reset clears state and restores register defaults.
// A stalled result holds the sequencer in its last step; a new request is
// taken while the previous result still waits.
`timescale 1ns / 1ps

module heading_angle_pid_rate_limited_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic signed [24:0]                measured_heading,
  input  logic signed [24:0]                target_heading,
  output logic                              drive_valid,
  input  logic                              drive_ready,
  output logic signed [24:0]                drive_value,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hapid_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  hapid_pkg::cfg_regs_t cfg;
  hapid_pkg::ctrl_cmd_t cmd;

  hapid_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hapid_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .drive_valid  (drive_valid),
    .drive_ready  (drive_ready),
    .cmd          (cmd)
  );

  hapid_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .measured_heading (measured_heading),
    .target_heading   (target_heading),
    .drive_value      (drive_value)
  );

`ifndef NO_ASSERTIONS
  // A request starts a computation: not ready again on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample_ready high right after a request was taken");

  // A result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!drive_valid || drive_ready))
    else $error("result register overwritten while still pending");

  // drive_valid only rises after the finish step
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(drive_valid) |-> $past(cmd.finish))
    else $error("drive_valid rose without a finish step");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the rate-limited heading PID core.
`timescale 1ns / 1ps

module testbench;

  localparam int     HEAD_MAX       = 11796480;
  localparam longint HALF_TURN_Q    = 64'sd11796480;
  localparam longint FULL_TURN_Q    = 64'sd23592960;
  localparam longint DEADBAND_Q     = 64'sd13107;
  localparam longint DECAY_Q        = 64'sd64225;
  localparam longint DEFAULT_STEP_Q = 64'sd13107;
  localparam longint S32_MAX        = 64'sd2147483647;
  localparam longint S32_MIN        = -64'sd2147483648;
  localparam int     WATCHDOG_LIMIT = 1000;

  typedef enum {PH_TYPICAL, PH_WIDE, PH_MAX, PH_CORNER} phase_kind_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                sample_valid;
  logic                                sample_ready;
  logic signed [24:0]                  measured_heading;
  logic signed [24:0]                  target_heading;
  logic                                drive_valid;
  logic                                drive_ready;
  logic signed [24:0]                  drive_value;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [hapid_pkg::APB_ADDR_W-1:0]    paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;

  // Predictor copy of the registers and loop history
  longint cfg_prop, cfg_integ, cfg_deriv, cfg_ilim, cfg_step, cfg_olim;
  longint integ_acc, last_err, last_drive;

  logic signed [24:0] pending_drive[$];

  int n_fail, n_sent, n_checked, n_writes;
  int n_wrapped, n_deadband, n_rate_limited, n_clamped;
  int last_meas, last_targ;
  int tx_free_run, rx_free_run;
  int stuck_cycles;

  heading_angle_pid_rate_limited_core dut (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .measured_heading (measured_heading),
    .target_heading   (target_heading),
    .drive_valid      (drive_valid),
    .drive_ready      (drive_ready),
    .drive_value      (drive_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #10 clk = ~clk;

  // Saturate to signed 32 bits
  function automatic longint sat_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Drop 16 fraction bits, rounding half away from zero
  function automatic longint round_q16(input longint v);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  function automatic int clip_heading(input int v);
    if (v > HEAD_MAX) return HEAD_MAX;
    if (v < -HEAD_MAX) return -HEAD_MAX;
    return v;
  endfunction

  // Wait length for one request; occasional runs with no waiting at all
  function automatic int draw_wait(inout int free_run);
    if (free_run > 0) begin
      free_run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      free_run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // One control step: wrap, integrate, PID sum, rate limit, clamp
  function automatic logic signed [24:0] predict_drive(input longint meas, input longint targ);
    longint err, acc, deriv, raw, lim, delta, drive;
    err = targ - meas;
    if (err > HALF_TURN_Q) begin
      err -= FULL_TURN_Q;
      n_wrapped++;
    end else if (err < -HALF_TURN_Q) begin
      err += FULL_TURN_Q;
      n_wrapped++;
    end

    // integral: decay inside the deadband, else add err / 250
    acc = integ_acc;
    if (err <= DEADBAND_Q && err >= -DEADBAND_Q) begin
      acc = round_q16(acc * DECAY_Q);
      n_deadband++;
    end else if (err >= 0) begin
      acc = sat_s32(acc + (err + 125) / 250);
    end else begin
      acc = sat_s32(acc - (-err + 125) / 250);
    end
    acc = clamp_mag(acc, cfg_ilim);

    deriv = sat_s32((err - last_err) * 250);

    raw = sat_s32(round_q16(cfg_prop * err));
    raw = sat_s32(raw + sat_s32(round_q16(cfg_integ * acc)));
    raw = sat_s32(raw + sat_s32(round_q16(cfg_deriv * deriv)));

    lim = (cfg_step != 0) ? cfg_step : DEFAULT_STEP_Q;
    if (raw - last_drive > lim || raw - last_drive < -lim) n_rate_limited++;
    delta = clamp_mag(raw - last_drive, lim);
    if (last_drive + delta > cfg_olim || last_drive + delta < -cfg_olim) n_clamped++;
    drive = clamp_mag(last_drive + delta, cfg_olim);

    integ_acc  = acc;
    last_err   = err;
    last_drive = drive;
    return drive[24:0];
  endfunction

  // APB write: setup, access, then idle
  task automatic write_reg(input hapid_pkg::cfg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      hapid_pkg::CFG_PROP_GAIN:  cfg_prop  = value[23:0];
      hapid_pkg::CFG_INTEG_GAIN: cfg_integ = value[23:0];
      hapid_pkg::CFG_DERIV_GAIN: cfg_deriv = value[23:0];
      hapid_pkg::CFG_INTEG_LIM:  cfg_ilim  = value[26:0];
      hapid_pkg::CFG_STEP_LIM:   cfg_step  = value[23:0];
      hapid_pkg::CFG_OUT_LIM:    cfg_olim  = value[23:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Send one sample request; valid stays up across back-to-back requests
  task automatic send_sample(input int meas, input int targ);
    int gap;
    gap = draw_wait(tx_free_run);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid     <= 1'b1;
    measured_heading <= meas[24:0];
    target_heading   <= targ[24:0];
    do @(posedge clk); while (!sample_ready);
    pending_drive.push_back(predict_drive(meas, targ));
    last_meas = meas;
    last_targ = targ;
    n_sent++;
  endtask

  // Hold off new requests until every expected drive has come back
  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_drive.size() != 0);
  endtask

  // Block idle: all results in, plus a wait for the history update
  task automatic settle();
    drain_results();
    repeat (4) @(posedge clk);
  endtask

  // Reset settings: wrap boundaries and deadband edges
  task automatic test_wrap_and_deadband();
    send_sample(0, 0);
    send_sample(0, HEAD_MAX);
    send_sample(0, -HEAD_MAX);
    send_sample(-1, HEAD_MAX);
    send_sample(1, -HEAD_MAX);
    send_sample(-HEAD_MAX, HEAD_MAX);
    send_sample(HEAD_MAX, -HEAD_MAX);
    send_sample(0, 13107);
    send_sample(0, -13107);
    send_sample(0, 13108);
    send_sample(0, -13108);
  endtask

  // All gains at their top value, wide limits: products and sums saturate
  task automatic test_saturation();
    settle();
    write_reg(hapid_pkg::CFG_PROP_GAIN, 32'h00FF_FFFF);
    write_reg(hapid_pkg::CFG_INTEG_GAIN, 32'h00FF_FFFF);
    write_reg(hapid_pkg::CFG_DERIV_GAIN, 32'h00FF_FFFF);
    write_reg(hapid_pkg::CFG_INTEG_LIM, 32'd67108864);
    write_reg(hapid_pkg::CFG_STEP_LIM, 32'd8388608);
    write_reg(hapid_pkg::CFG_OUT_LIM, 32'd8388608);
    send_sample(0, HEAD_MAX);
    send_sample(0, -HEAD_MAX);
    send_sample(HEAD_MAX, -HEAD_MAX);
    send_sample(-HEAD_MAX, HEAD_MAX - 1);
    send_sample(5, 0);
  endtask

  // Zero output limit forces zero drive; zero step limit means 0.2 per step
  task automatic test_zero_limits();
    settle();
    write_reg(hapid_pkg::CFG_OUT_LIM, 32'd0);
    send_sample(0, HEAD_MAX);
    send_sample(HEAD_MAX, 0);
    send_sample(-4000000, 3000000);
    settle();
    write_reg(hapid_pkg::CFG_OUT_LIM, 32'd8388608);
    write_reg(hapid_pkg::CFG_STEP_LIM, 32'd0);
    write_reg(hapid_pkg::CFG_PROP_GAIN, 32'd65536);
    send_sample(0, 6000000);
    send_sample(0, 6000000);
    send_sample(0, -6000000);
  endtask

  // Register value with junk above the register width now and then
  function automatic logic [31:0] with_noise(input logic [31:0] value, input int width);
    if ($urandom_range(0, 1) == 0) return value;
    return value | ($urandom << width);
  endfunction

  task automatic load_phase_config(input phase_kind_t kind);
    logic [31:0] v[6];
    case (kind)
      PH_TYPICAL: begin
        v[0] = $urandom_range(0, 262144);
        v[1] = $urandom_range(0, 65536);
        v[2] = $urandom_range(0, 262144);
        v[3] = $urandom_range(0, 196608);
        v[4] = $urandom_range(0, 1) ? 0 : $urandom_range(1, 65536);
        v[5] = $urandom_range(6554, 131072);
      end
      PH_WIDE: begin
        v[0] = $urandom_range(0, 24'hFFFFFF);
        v[1] = $urandom_range(0, 24'hFFFFFF);
        v[2] = $urandom_range(0, 24'hFFFFFF);
        v[3] = $urandom_range(0, 67108864);
        v[4] = $urandom_range(0, 8388608);
        v[5] = $urandom_range(0, 8388608);
      end
      PH_MAX: begin
        v[0] = 24'hFFFFFF;
        v[1] = 24'hFFFFFF;
        v[2] = 24'hFFFFFF;
        v[3] = 67108864;
        v[4] = 8388608;
        v[5] = 8388608;
      end
      default: begin
        v[0] = $urandom_range(0, 1) ? 0 : 24'hFFFFFF;
        v[1] = $urandom_range(0, 1) ? 0 : 24'hFFFFFF;
        v[2] = $urandom_range(0, 1) ? 0 : 24'hFFFFFF;
        v[3] = $urandom_range(0, 1) ? 0 : 67108864;
        v[4] = $urandom_range(0, 2) == 0 ? 1 : ($urandom_range(0, 1) ? 0 : 8388608);
        v[5] = $urandom_range(0, 2) == 0 ? 1 : ($urandom_range(0, 1) ? 0 : 8388608);
      end
    endcase
    for (int i = 0; i < 6; i++)
      write_reg(hapid_pkg::cfg_idx_t'(i), with_noise(v[i], (i == 3) ? 27 : 24));
  endtask

  // Random requests: mostly tracking and walking headings, some wrap edges
  task automatic test_random_phase(input phase_kind_t kind, input int count);
    int meas, targ, d, pick;
    settle();
    load_phase_config(kind);
    for (int i = 0; i < count; i++) begin
      if (i == count / 4 || $urandom_range(0, 299) == 0) drain_results();
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        meas = int'($urandom_range(0, 2 * HEAD_MAX)) - HEAD_MAX;
        targ = int'($urandom_range(0, 2 * HEAD_MAX)) - HEAD_MAX;
      end else if (pick < 12) begin
        // hold near target so the deadband and decay get exercised
        targ = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2 * HEAD_MAX)) - HEAD_MAX
                                           : last_targ;
        meas = clip_heading(targ - (int'($urandom_range(0, 40000)) - 20000));
      end else if (pick < 15) begin
        // error a few LSBs either side of a half turn
        meas = -int'($urandom_range(3, HEAD_MAX));
        d    = int'($urandom_range(0, 6)) - 3;
        targ = meas + HEAD_MAX + d;
        if ($urandom_range(0, 1)) begin
          meas = -meas;
          targ = -targ;
        end
      end else begin
        meas = clip_heading(last_meas + int'($urandom_range(0, 400000)) - 200000);
        targ = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2 * HEAD_MAX)) - HEAD_MAX
                                           : last_targ;
      end
      send_sample(meas, targ);
    end
  endtask

  // Drive result receiver and checker
  initial begin
    int stall;
    logic signed [24:0] want;
    drive_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(rx_free_run);
      if (stall > 0) begin
        drive_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      drive_ready <= 1'b1;
      do @(posedge clk); while (!drive_valid);
      if (pending_drive.size() == 0) begin
        $error("drive_value: unexpected result, actual %0d", drive_value);
        n_fail++;
      end else begin
        want = pending_drive.pop_front();
        if (drive_value !== want) begin
          $error("drive_value mismatch: expected %0d, actual %0d", want, drive_value);
          n_fail++;
        end
        n_checked++;
      end
    end
  end

  // Progress watchdog: any accepted request, result or register write counts
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (drive_valid && drive_ready) ||
        (psel && penable && pready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("heading_angle_pid_rate_limited_core test failed");
    $finish;
  end

  // Test sequence
  initial begin
    rst              = 1'b1;
    sample_valid     = 1'b0;
    measured_heading = '0;
    target_heading   = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cfg_prop   = hapid_pkg::PROP_GAIN_RST;
    cfg_integ  = hapid_pkg::INTEG_GAIN_RST;
    cfg_deriv  = hapid_pkg::DERIV_GAIN_RST;
    cfg_ilim   = hapid_pkg::INTEG_LIM_RST;
    cfg_step   = hapid_pkg::STEP_LIM_RST;
    cfg_olim   = hapid_pkg::OUT_LIM_RST;
    integ_acc  = 0;
    last_err   = 0;
    last_drive = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_wrap_and_deadband();
    test_saturation();
    test_zero_limits();
    test_random_phase(PH_TYPICAL, 255);
    test_random_phase(PH_WIDE, 255);
    test_random_phase(PH_MAX, 255);
    test_random_phase(PH_CORNER, 255);
    test_random_phase(PH_TYPICAL, 255);
    test_random_phase(PH_WIDE, 255);

    settle();
    repeat (16) @(posedge clk);
    n_fail += pending_drive.size();

    $display("Sent %0d heading samples, checked %0d drive results, %0d register writes.",
             n_sent, n_checked, n_writes);
    $display("Wrapped errors %0d, deadband decays %0d, step-limited %0d, output-clamped %0d.",
             n_wrapped, n_deadband, n_rate_limited, n_clamped);
    if (n_fail == 0) begin
      $display("heading_angle_pid_rate_limited_core test passed");
    end else begin
      $display("heading_angle_pid_rate_limited_core test failed");
    end
    $finish;
  end

endmodule
